FILE: sv/assert_macros.svh
// assertion macros for the ordered value list
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define OVL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked in the next cycle outside reset
`define OVL_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: sv/ovl_pkg.sv
// types and constants of the ordered value list
package ovl_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	// per-transfer control handed to every cell
	typedef struct packed {
		logic append;
		logic remove;
	} ovl_ctrl_t;

	typedef struct packed {
		logic               found;
		logic [POS_W-1:0]   position;
		logic [COUNT_W-1:0] entry_count;
		logic               is_empty;
		logic               overflow;
	} ovl_result_t;

endpackage

FILE: sv/ovl_cell.sv
// one list cell: holds an entry, compares it with the key, shifts on remove
module ovl_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ovl_pkg::ovl_ctrl_t           ctrl,
	input  logic [ovl_pkg::VALUE_W-1:0]  key,
	input  logic                         hit_in,
	input  logic                         prev_valid,
	input  logic [ovl_pkg::VALUE_W-1:0]  next_value,
	input  logic                         next_valid,
	output logic                         hit_out,
	output logic                         first_hit,
	output logic [ovl_pkg::VALUE_W-1:0]  value,
	output logic                         valid
);
	import ovl_pkg::*;

	logic [VALUE_W-1:0] value_q;
	logic               valid_q;
	logic               match;
	logic               take_key;
	logic               take_next;

	assign match     = valid_q && (value_q == key);
	assign hit_out   = hit_in | match;
	assign first_hit = match & ~hit_in;

	// the tail cell is the first empty one
	assign take_key  = ctrl.append && !valid_q && prev_valid;
	// cells at and after the removed entry move up by one
	assign take_next = ctrl.remove && hit_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_key) begin
			valid_q <= 1'b1;
		end else if (take_next) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_key) begin
			value_q <= key;
		end else if (take_next) begin
			value_q <= next_value;
		end
	end

	assign value = value_q;
	assign valid = valid_q;

endmodule

FILE: sv/ovl_result_reg.sv
// output register for results, frees the input side when empty or drained
module ovl_result_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  ovl_pkg::ovl_result_t  result,
	output logic                  ready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output ovl_pkg::ovl_result_t  held
);
	import ovl_pkg::*;

	logic        valid_q;
	ovl_result_t result_q;

	assign ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

	assign m_tvalid = valid_q;
	assign held     = result_q;

endmodule

FILE: sv/ordered_value_list.sv
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells.
// Each input transfer carries an operation in s_tuser (append, remove first
// match, search first match) and a value in s_tdata. When a transfer is taken,
// every cell compares its entry with the value at once, a first-match chain
// runs through the row, and on remove the matching cell and the cells behind it
// take their neighbor's entry. One transfer is accepted per cycle while the
// output register is free or being read; the result appears there in the cycle
// after acceptance. The row's compare and first-match chain set the clock
// period. A full list drops and flags an append. Reset empties the list.
`include "assert_macros.svh"

module ordered_value_list (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value[31:0]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// found[0], position[4:1], entry_count[9:5], is_empty[10], overflow[11], zero[15:12]
	output logic [15:0] m_tdata
);
	import ovl_pkg::*;

	logic               accept;
	logic               full;
	logic               found;
	logic               do_append;
	logic               do_remove;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_next;
	logic [POS_W-1:0]   position;
	ovl_ctrl_t          ctrl;
	ovl_result_t        result;
	ovl_result_t        held;

	logic [CAPACITY:0]  hit_chain;
	logic [CAPACITY-1:0] first_hit;
	logic [CAPACITY-1:0] valid_vec;
	logic [VALUE_W-1:0] value_vec [CAPACITY];

	assign accept    = s_tvalid && s_tready;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign do_append = accept && (s_tuser == OP_APPEND);
	assign do_remove = accept && (s_tuser == OP_REMOVE);

	assign ctrl.append = do_append;
	assign ctrl.remove = do_remove;

	assign hit_chain[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic               prev_valid;
		logic [VALUE_W-1:0] next_value;
		logic               next_valid;

		if (i == 0) begin : g_head
			assign prev_valid = 1'b1;
		end else begin : g_body
			assign prev_valid = valid_vec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_value = value_vec[i];
			assign next_valid = 1'b0;
		end else begin : g_mid
			assign next_value = value_vec[i+1];
			assign next_valid = valid_vec[i+1];
		end

		ovl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.key        (s_tdata),
			.hit_in     (hit_chain[i]),
			.prev_valid (prev_valid),
			.next_value (next_value),
			.next_valid (next_valid),
			.hit_out    (hit_chain[i+1]),
			.first_hit  (first_hit[i]),
			.value      (value_vec[i]),
			.valid      (valid_vec[i])
		);
	end

	// first_hit is one-hot or zero, so an or of the indices encodes it
	always_comb begin
		position = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_hit[i]) begin
				position = position | POS_W'(i);
			end
		end
	end

	always_comb begin
		found = hit_chain[CAPACITY] && ((s_tuser == OP_REMOVE) || (s_tuser == OP_SEARCH));
		count_next = count_q;
		priority if (s_tuser == OP_APPEND && !full) begin
			count_next = count_q + CNT_W'(1);
		end else if (s_tuser == OP_REMOVE && found) begin
			count_next = count_q - CNT_W'(1);
		end else begin
			count_next = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	assign result.found       = found;
	assign result.position    = found ? position : '0;
	assign result.entry_count = COUNT_W'(count_next);
	assign result.is_empty    = (count_next == '0);
	assign result.overflow    = (s_tuser == OP_APPEND) && full;

	ovl_result_reg u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.result   (result),
		.ready    (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.held     (held)
	);

	assign m_tdata = {4'b0000, held.overflow, held.is_empty, held.entry_count,
		held.position, held.found};

	`OVL_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`OVL_ASSERT(a_valid_count, $countones(valid_vec) == int'(count_q), "valid cells off count")
	`OVL_ASSERT(a_first_hit, $onehot0(first_hit), "more than one first match")
	`OVL_ASSERT_NEXT(a_append_grows, do_append && !full,
		count_q == $past(count_q) + CNT_W'(1), "append did not grow the list")

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the ordered value list: scoreboard class, drivers and monitor
`timescale 1ns / 1ps

module tb_top;
	import ovl_pkg::*;

	localparam logic [1:0] OP_NOP       = 2'd3;
	localparam int         RANDOM_ITEMS = 920;
	localparam int         HOLD_CYCLES  = 90;
	localparam int         TAIL_CYCLES  = 12;
	localparam int         LIMIT        = 400000;
	localparam int         POOL_N       = 8;

	class list_scoreboard;
		localparam int MAX_REPORTS = 10;
		logic [VALUE_W-1:0] held[$];
		ovl_result_t        awaited[$];
		int                 errors = 0;

		// update the list copy and queue the result this transfer should produce
		function void note_input(logic [1:0] op, logic [VALUE_W-1:0] key);
			ovl_result_t r;
			int          idx;
			r   = '0;
			idx = -1;
			case (op)
				OP_APPEND: begin
					if (held.size() < CAPACITY) held.push_back(key);
					else r.overflow = 1'b1;
				end
				OP_REMOVE, OP_SEARCH: begin
					foreach (held[i]) if (idx < 0 && held[i] == key) idx = i;
					if (idx >= 0) begin
						r.found    = 1'b1;
						r.position = POS_W'(idx);
						if (op == OP_REMOVE) held.delete(idx);
					end
				end
				default: ;
			endcase
			r.entry_count = COUNT_W'(held.size());
			r.is_empty    = (held.size() == 0);
			awaited.push_back(r);
		endfunction

		function void check_result(logic [15:0] d);
			ovl_result_t want;
			ovl_result_t got;
			got.found       = d[0];
			got.position    = d[4:1];
			got.entry_count = d[9:5];
			got.is_empty    = d[10];
			got.overflow    = d[11];
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) $display("result %h with nothing outstanding", d);
				return;
			end
			want = awaited.pop_front();
			if (got.found !== want.found || got.position !== want.position ||
			    got.entry_count !== want.entry_count || got.is_empty !== want.is_empty ||
			    got.overflow !== want.overflow || d[15:12] !== 4'd0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("mismatch: found %b/%b pos %0d/%0d count %0d/%0d empty %b/%b ovf %b/%b pad %h",
					         want.found, got.found, want.position, got.position,
					         want.entry_count, got.entry_count, want.is_empty, got.is_empty,
					         want.overflow, got.overflow, d[15:12]);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // value[31:0]
	logic [1:0]  s_tuser;  // operation[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // found[0], position[4:1], entry_count[9:5], is_empty[10], overflow[11]

	list_scoreboard sb = new();
	bit             hold_req = 1'b0;
	int             burst = 0;
	int             cycle_count = 0;

	ordered_value_list u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk      = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_APPEND;
		m_tready = 1'b0;
	end

	always #6 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic offer(input logic [1:0] op, input logic [31:0] val);
		int gap;
		gap = (burst > 0) ? 0 : pick_gap();
		if (burst > 0) burst--;
		else if ($urandom_range(0, 39) == 0) burst = 30;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= val;
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
	endtask

	// wait from the edge after the last transfer until every result has been checked
	task automatic wait_drained();
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
		end
	end

	initial begin : receiver
		int stall_len;
		int calm;
		int held_cycles;
		calm = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				for (held_cycles = 0; held_cycles < HOLD_CYCLES; held_cycles++) @(posedge clk);
			end else begin
				stall_len = (calm > 0) ? 0 : pick_gap();
				if (calm > 0) calm--;
				else if ($urandom_range(0, 49) == 0) calm = 40;
				if (stall_len > 0) begin
					m_tready <= 1'b0;
					repeat (stall_len) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : watchdog
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] pool [POOL_N];
		logic [1:0]  op;
		logic [31:0] val;
		int          counted;
		int          iter;
		int          r;
		int          k;
		bit          filling;
		bit          hold_done;
		bit          drain_done;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corner cases
		offer(OP_SEARCH, 32'h0000_0000);
		offer(OP_REMOVE, 32'hFFFF_FFFF);
		offer(OP_NOP,    32'h8000_0000);
		// extremes and a duplicate
		offer(OP_APPEND, 32'h7FFF_FFFF);
		offer(OP_APPEND, 32'h8000_0000);
		offer(OP_APPEND, 32'h0000_0000);
		offer(OP_APPEND, 32'hFFFF_FFFF);
		offer(OP_APPEND, 32'h7FFF_FFFF);
		offer(OP_SEARCH, 32'h7FFF_FFFF);
		offer(OP_REMOVE, 32'h7FFF_FFFF);
		offer(OP_SEARCH, 32'h7FFF_FFFF);
		// fill up to capacity, last entry unique
		for (k = 0; k < 12; k++)
			offer(OP_APPEND, (k == 11) ? 32'h1234_5678 :
			                 (k[0] ? 32'hAAAA_AAAA : 32'h5555_5555));
		offer(OP_SEARCH, 32'h1234_5678);
		offer(OP_APPEND, 32'hDEAD_BEEF);
		offer(OP_NOP,    32'hFFFF_FFFF);
		offer(OP_REMOVE, 32'h5555_5555);
		offer(OP_REMOVE, 32'h1357_9BDF);
		offer(OP_SEARCH, 32'h8000_0000);

		counted    = 0;
		iter       = 0;
		filling    = 1'b0;
		hold_done  = 1'b0;
		drain_done = 1'b0;
		while (counted < RANDOM_ITEMS) begin
			if (iter % 120 == 0) begin
				foreach (pool[i]) begin
					case ($urandom_range(0, 9))
						0:       pool[i] = 32'h8000_0000;
						1:       pool[i] = 32'h7FFF_FFFF;
						2:       pool[i] = 32'hFFFF_FFFF;
						3:       pool[i] = 32'h0000_0000;
						default: pool[i] = $urandom();
					endcase
				end
			end
			// alternate between growing and shrinking so full and empty both recur
			if (iter % 48 == 0) filling = ~filling;
			iter++;

			r = $urandom_range(0, 99);
			if (r < 4) op = OP_NOP;
			else if (filling) op = (r < 64) ? OP_APPEND : ((r < 82) ? OP_REMOVE : OP_SEARCH);
			else op = (r < 28) ? OP_APPEND : ((r < 70) ? OP_REMOVE : OP_SEARCH);
			val = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, POOL_N - 1)] : $urandom();

			if (counted == 300 && !hold_done) begin
				hold_done = 1'b1;
				hold_req  = 1'b1;
				burst     = 40;
			end
			if (counted == 600 && !drain_done) begin
				drain_done = 1'b1;
				s_tvalid <= 1'b0;
				wait_drained();
			end

			offer(op, val);
			if (op != OP_NOP) counted++;
		end

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
